### sv/spq_pkg.sv
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

	localparam int CAPACITY_DEF     = 16;
	localparam int SCORE_BITS_DEF   = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int IN_SCORE_W    = 16;
	localparam int IN_PAYLOAD_W  = 32;
	localparam int OUT_COUNT_W   = 5;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                    action;
		logic [IN_SCORE_W-1:0]   new_score;
		logic [IN_PAYLOAD_W-1:0] new_payload;
	} spq_in_t;

	typedef struct packed {
		logic [IN_SCORE_W-1:0]   out_score;
		logic [IN_PAYLOAD_W-1:0] out_payload;
		logic [1:0]              status;
		logic [OUT_COUNT_W-1:0]  count;
	} spq_out_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctrl_t;

endpackage

### sv/sorted_priority_queue.sv
// top level: sorted priority queue built as a chain of compare-and-shift cells
// the result is registered for the next cycle; throughput: one beat per cycle
// while the receiver keeps up; every cell compares against the new score at once
// and the chain shifts in the same edge, so the count register is the only loop
// reset: asynchronous, clears the entry count and the output valid; cell contents
// stay undefined and are never read before they are written
module sorted_priority_queue #(
	parameter int CAPACITY     = spq_pkg::CAPACITY_DEF,
	parameter int SCORE_BITS   = spq_pkg::SCORE_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  spq_pkg::spq_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output spq_pkg::spq_out_t out_data
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int SXW = SCORE_BITS + spq_pkg::IN_SCORE_W;
	localparam int PXW = PAYLOAD_BITS + spq_pkg::IN_PAYLOAD_W;

	logic [CW-1:0] count_q;
	logic          out_valid_q;
	spq_pkg::spq_out_t out_q;

	logic accept;
	logic full, empty;
	spq_pkg::spq_ctrl_t ctrl;

	// input fields resized to storage width (mask or zero-extend)
	logic [SXW-1:0]          sc_ext;
	logic [PXW-1:0]          pl_ext;
	logic [SCORE_BITS-1:0]   in_sc;
	logic [PAYLOAD_BITS-1:0] in_pl;

	// head entry resized to the port widths
	logic [SXW-1:0] head_sc_ext;
	logic [PXW-1:0] head_pl_ext;

	logic [CW-1:0]                count_d;
	logic [CW+spq_pkg::OUT_COUNT_W-1:0] count_ext;
	spq_pkg::spq_out_t            res;

	// chain wiring
	logic [SCORE_BITS-1:0]   cell_sc [CAPACITY];
	logic [PAYLOAD_BITS-1:0] cell_pl [CAPACITY];
	logic                    cell_ge [CAPACITY];

	// output register frees as soon as its beat is taken
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	assign sc_ext = SXW'(in_data.new_score);
	assign pl_ext = PXW'(in_data.new_payload);
	assign in_sc  = sc_ext[SCORE_BITS-1:0];
	assign in_pl  = pl_ext[PAYLOAD_BITS-1:0];

	assign head_sc_ext = SXW'(cell_sc[0]);
	assign head_pl_ext = PXW'(cell_pl[0]);

	// only legal operations move the chain
	assign ctrl.enq = accept && (in_data.action == spq_pkg::ACT_ENQ) && !full;
	assign ctrl.deq = accept && (in_data.action == spq_pkg::ACT_DEQ) && !empty;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                    l_ge;
			logic [SCORE_BITS-1:0]   l_sc, r_sc;
			logic [PAYLOAD_BITS-1:0] l_pl, r_pl;

			if (gi == 0) begin : g_head
				// nothing ranks ahead of the head slot
				assign l_ge = 1'b1;
				assign l_sc = in_sc;
				assign l_pl = in_pl;
			end else begin : g_mid
				assign l_ge = cell_ge[gi-1];
				assign l_sc = cell_sc[gi-1];
				assign l_pl = cell_pl[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				// tail keeps its content on a dequeue; it falls out of the count
				assign r_sc = cell_sc[gi];
				assign r_pl = cell_pl[gi];
			end else begin : g_body
				assign r_sc = cell_sc[gi+1];
				assign r_pl = cell_pl[gi+1];
			end

			spq_cell #(
				.SCORE_BITS  (SCORE_BITS),
				.PAYLOAD_BITS(PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.occ          (CW'(gi) < count_q),
				.new_score    (in_sc),
				.new_payload  (in_pl),
				.left_ge      (l_ge),
				.left_score   (l_sc),
				.left_payload (l_pl),
				.right_score  (r_sc),
				.right_payload(r_pl),
				.ge           (cell_ge[gi]),
				.score        (cell_sc[gi]),
				.payload      (cell_pl[gi])
			);
		end
	endgenerate

	// result beat and next count
	always_comb begin
		res.out_score   = '0;
		res.out_payload = '0;
		res.status      = spq_pkg::ST_OK;
		count_d         = count_q;
		unique case (in_data.action)
			spq_pkg::ACT_DEQ: begin
				if (empty) begin
					res.status = spq_pkg::ST_EMPTY;
				end else begin
					res.out_score   = head_sc_ext[spq_pkg::IN_SCORE_W-1:0];
					res.out_payload = head_pl_ext[spq_pkg::IN_PAYLOAD_W-1:0];
					count_d         = count_q - CW'(1);
				end
			end
			default: begin
				if (full) begin
					res.status = spq_pkg::ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
		endcase
		count_ext = (CW + spq_pkg::OUT_COUNT_W)'(count_d);
		res.count = count_ext[spq_pkg::OUT_COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted beat produced no result");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> count_q == $past(count_q) - CW'(1))
		else $error("dequeue did not drop the count");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not raise the count");

	a_no_move_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ctrl.enq && !ctrl.deq) |=> $stable(count_q))
		else $error("rejected operation changed the count");
`endif

endmodule

### sv/spq_cell.sv
// one slot of the sorted chain: holds an entry, keeps, shifts or loads it
module spq_cell #(
	parameter int SCORE_BITS   = spq_pkg::SCORE_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  spq_pkg::spq_ctrl_t      ctrl,
	input  logic                    occ,
	input  logic [SCORE_BITS-1:0]   new_score,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    left_ge,
	input  logic [SCORE_BITS-1:0]   left_score,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic [SCORE_BITS-1:0]   right_score,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                    ge,
	output logic [SCORE_BITS-1:0]   score,
	output logic [PAYLOAD_BITS-1:0] payload
);

	logic [SCORE_BITS-1:0]   score_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// stored entry ranks ahead of the new one (ties stay ahead)
	assign ge      = occ && (score_q >= new_score);
	assign score   = score_q;
	assign payload = payload_q;

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			score_q   <= right_score;
			payload_q <= right_payload;
		end else if (ctrl.enq && !ge) begin
			if (left_ge) begin
				score_q   <= new_score;
				payload_q <= new_payload;
			end else begin
				score_q   <= left_score;
				payload_q <= left_payload;
			end
		end
	end

endmodule

### sim/tb.sv
// self-checking testbench for the sorted priority queue
`timescale 1ns / 100ps

module tb;

	// queue depth the predictor mirrors, matching the block's default
	localparam int CAP = spq_pkg::CAPACITY_DEF;
	// cycles without any accepted beat before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// length of the deliberate receiver hold-off that backs up the input
	localparam int HOLD_CYCLES = 64;
	// random beats per phase, four phases in all
	localparam int BEATS_PER_PHASE = 112;
	localparam int DIR_ROWS = 25;

	// one stimulus beat, with a result typed in where it is obvious
	typedef struct {
		spq_pkg::spq_in_t  beat;
		bit                pinned;
		spq_pkg::spq_out_t want;
	} row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	spq_pkg::spq_in_t  in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	spq_pkg::spq_out_t out_data;

	// predictor state: entries sorted by score, head at index 0
	logic [spq_pkg::IN_SCORE_W-1:0]   pq_score[CAP];
	logic [spq_pkg::IN_PAYLOAD_W-1:0] pq_payload[CAP];
	int                               pq_len = 0;

	row_t              dir_rows[DIR_ROWS];
	row_t              offered_rows[$];  // beats offered, waiting to be accepted
	spq_pkg::spq_out_t result_q[$];      // results owed by the block, oldest first

	int errors    = 0;
	int offered   = 0;
	int in_taken  = 0;
	int idle_run  = 0;
	int gap_pct   = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_req  = 1'b0;

	sorted_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	function automatic spq_pkg::spq_in_t beat(input logic act, input logic [15:0] sc,
			input logic [31:0] pl);
		spq_pkg::spq_in_t b;
		b.action      = act;
		b.new_score   = sc;
		b.new_payload = pl;
		return b;
	endfunction

	function automatic spq_pkg::spq_out_t res(input logic [15:0] sc,
			input logic [31:0] pl, input logic [1:0] st, input int cnt);
		spq_pkg::spq_out_t r;
		r.out_score   = sc;
		r.out_payload = pl;
		r.status      = st;
		r.count       = spq_pkg::OUT_COUNT_W'(cnt);
		return r;
	endfunction

	// applies one beat to the mirrored queue and returns the result it owes
	function automatic spq_pkg::spq_out_t queue_step(input spq_pkg::spq_in_t b);
		spq_pkg::spq_out_t r;
		int pos;
		r = '0;
		if (b.action == spq_pkg::ACT_DEQ) begin
			if (pq_len == 0) begin
				// nothing to hand out, state untouched
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				r.out_score   = pq_score[0];
				r.out_payload = pq_payload[0];
				for (int i = 1; i < pq_len; i++) begin
					pq_score[i-1]   = pq_score[i];
					pq_payload[i-1] = pq_payload[i];
				end
				pq_len--;
				r.status = spq_pkg::ST_OK;
			end
		end else if (pq_len >= CAP) begin
			// full: the new entry is dropped
			r.status = spq_pkg::ST_FULL;
		end else begin
			// ties keep arrival order: skip every entry scoring >= the new one
			pos = 0;
			while (pos < pq_len && pq_score[pos] >= b.new_score)
				pos++;
			for (int i = pq_len; i > pos; i--) begin
				pq_score[i]   = pq_score[i-1];
				pq_payload[i] = pq_payload[i-1];
			end
			pq_score[pos]   = b.new_score;
			pq_payload[pos] = b.new_payload;
			pq_len++;
			r.status = spq_pkg::ST_OK;
		end
		r.count = spq_pkg::OUT_COUNT_W'(pq_len);
		return r;
	endfunction

	// scores lean toward a narrow band so ties are common, and toward the extremes
	function automatic spq_pkg::spq_in_t rand_beat(input int enq_pct);
		spq_pkg::spq_in_t b;
		b.action = ($urandom_range(99) < enq_pct) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ;
		case ($urandom_range(3))
			0: b.new_score = 16'($urandom_range(3));
			1: b.new_score = 16'hFFFF - 16'($urandom_range(3));
			default: b.new_score = 16'($urandom);
		endcase
		b.new_payload = $urandom;
		return b;
	endfunction

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// offers one beat at a falling edge and returns at the falling edge after it
	// was taken; valid only drops for an idle gap, never between back-to-back beats
	task automatic send(input spq_pkg::spq_in_t b, input bit pinned,
			input spq_pkg::spq_out_t want);
		int gap;
		row_t r;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < gap_pct)
			gap++;
		r.beat   = b;
		r.pinned = pinned;
		r.want   = want;
		offered_rows.push_back(r);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		offered++;
		do @(negedge clk); while (in_taken < offered);
	endtask

	// receiver: random stalls per phase, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: predicts on every accepted input beat, checks every result beat,
	// and watches for a hang; input is handled first so a same-edge result
	// still pairs with the oldest expectation
	always @(posedge clk) begin
		row_t              took;
		spq_pkg::spq_out_t guess;
		spq_pkg::spq_out_t got;
		bit                moved;
		moved = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			moved = 1'b1;
			took  = offered_rows.pop_front();
			guess = queue_step(in_data);
			// a typed-in result overrides the predictor for directed rows
			result_q.push_back(took.pinned ? took.want : guess);
			in_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			moved = 1'b1;
			got   = out_data;
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none actual %h",
					$time, got);
			end else begin
				guess = result_q.pop_front();
				check_field("out_score", guess.out_score, got.out_score);
				check_field("out_payload", guess.out_payload, got.out_payload);
				check_field("status", guess.status, got.status);
				check_field("count", guess.count, got.count);
			end
		end
		idle_run = moved ? 0 : idle_run + 1;
		if (idle_run >= HANG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int enq_pct;
		enq_pct = 50;

		// directed rows: empty dequeue with junk fields, extreme scores and
		// payloads, tie order, drain back to empty
		dir_rows[0] = '{beat(spq_pkg::ACT_DEQ, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_EMPTY, 0)};
		dir_rows[1] = '{beat(spq_pkg::ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_OK, 1)};
		dir_rows[2] = '{beat(spq_pkg::ACT_ENQ, 16'h0000, 32'h0000_0000), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_OK, 2)};
		dir_rows[3] = '{beat(spq_pkg::ACT_ENQ, 16'hFFFF, 32'h0000_0001), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_OK, 3)};
		// equal top scores come out in arrival order
		dir_rows[4] = '{beat(spq_pkg::ACT_DEQ, 16'h0000, 32'h0000_0000), 1'b1,
			res(16'hFFFF, 32'hFFFF_FFFF, spq_pkg::ST_OK, 2)};
		dir_rows[5] = '{beat(spq_pkg::ACT_DEQ, 16'h5A5A, 32'hA5A5_A5A5), 1'b1,
			res(16'hFFFF, 32'h0000_0001, spq_pkg::ST_OK, 1)};
		dir_rows[6] = '{beat(spq_pkg::ACT_DEQ, 16'h0000, 32'h0000_0000), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_OK, 0)};
		dir_rows[7] = '{beat(spq_pkg::ACT_DEQ, 16'h0000, 32'h0000_0000), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_EMPTY, 0)};
		// fill to capacity with mixed scores and repeated ties
		for (int i = 0; i < CAP; i++)
			dir_rows[8+i] = '{beat(spq_pkg::ACT_ENQ,
				(i % 3 == 0) ? 16'h8000 : 16'(i * 16'h0F0F),
				32'hC0DE_0000 | i), 1'b0, '0};
		// one more enqueue on a full queue is refused
		dir_rows[24] = '{beat(spq_pkg::ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
			res(16'h0, 32'h0, spq_pkg::ST_FULL, CAP)};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);

		// random phases: no idling, sender idle, receiver stalling, both
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 58; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 58; end
				default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			for (int k = 0; k < BEATS_PER_PHASE; k++) begin
				// bursts lean toward filling, churning or draining the queue
				if (k % 24 == 0) begin
					case ($urandom_range(2))
						0: enq_pct = 85;
						1: enq_pct = 50;
						default: enq_pct = 15;
					endcase
				end
				// long receiver hold-off while beats keep coming, backs up the input
				if (p == 0 && k == 40)
					hold_req = 1'b1;
				send(rand_beat(enq_pct), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// drain owed results; the watchdog catches a hang here
		while (result_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
